[rtl/swrl_pkg.sv]
// Shared types, field widths, register indexes and controller encodings of the rate limiter.
package swrl_pkg;

  localparam int NOW_W      = 48;
  localparam int ID_W       = 32;
  localparam int VOL_W      = 32;
  localparam int PERIOD_W   = 27;
  localparam int CLIMIT_W   = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef logic [NOW_W-1:0]      now_t;
  typedef logic [ID_W-1:0]       id_t;
  typedef logic [VOL_W-1:0]      vol_t;
  typedef logic [PERIOD_W-1:0]   period_t;
  typedef logic [CLIMIT_W-1:0]   climit_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_WINDOW_PERIOD = 2'd0;
  localparam cfg_idx_t CFG_COUNT_LIMIT   = 2'd1;
  localparam cfg_idx_t CFG_VOLUME_CAP    = 2'd2;

  // Item kinds.
  localparam logic KIND_CHECK  = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CNT_RD,
    ST_CNT_CMP,
    ST_VOL_RD,
    ST_VOL_CMP,
    ST_RB_RD,
    ST_RB_CMP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic latch;
    logic rd_tail;
    logic c_evict;
    logic c_append;
    logic v_evict;
    logic v_append;
    logic rollback;
    logic verdict_set;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic kind;
    logic not_sent;
    logic disabled;
    logic c_en;
    logic v_en;
    logic c_evict;
    logic c_full;
    logic v_evict;
    logic v_over;
    logic v_full;
  } dp_status_t;

endpackage

[rtl/swrl_req_if.sv]
// Request channel: check and rejection beats with valid and ready.
interface swrl_req_if;
  import swrl_pkg::*;

  logic valid;
  logic ready;
  logic kind;
  now_t now_ms;
  id_t  request_id;
  vol_t request_volume;
  logic not_sent;

  modport source (output valid, output kind, output now_ms, output request_id,
                  output request_volume, output not_sent, input ready);
  modport sink   (input valid, input kind, input now_ms, input request_id,
                  input request_volume, input not_sent, output ready);
endinterface

[rtl/swrl_rsp_if.sv]
// Response channel: one verdict beat per request beat.
interface swrl_rsp_if;
  logic valid;
  logic ready;
  logic verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface

[rtl/swrl_cfg_if.sv]
// Configuration write channel: register index and write data with valid and ready.
interface swrl_cfg_if;
  import swrl_pkg::*;

  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/swrl_datapath.sv]
// Datapath of the rate limiter: configuration, both log memories, pointers and volume sum.
module swrl_datapath #(
  parameter int LOG_DEPTH = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  swrl_pkg::dp_cmd_t      cmd,
  output swrl_pkg::dp_status_t   status,
  input  logic                   kind,
  input  swrl_pkg::now_t         now_ms,
  input  swrl_pkg::id_t          request_id,
  input  swrl_pkg::vol_t         request_volume,
  input  logic                   not_sent,
  input  logic                   cfg_we,
  input  swrl_pkg::cfg_idx_t     cfg_index,
  input  swrl_pkg::cfg_data_t    cfg_data,
  output logic                   verdict
);
  import swrl_pkg::*;

  localparam int IW   = $clog2(LOG_DEPTH);
  localparam int FW   = $clog2(LOG_DEPTH + 1);
  localparam int SW   = $clog2(2 * LOG_DEPTH);
  localparam int CMPW = (FW > CLIMIT_W) ? FW : CLIMIT_W;
  localparam logic [FW-1:0] FILL_FULL = FW'(LOG_DEPTH);
  localparam logic [IW-1:0] IDX_LAST  = IW'(LOG_DEPTH - 1);
  localparam logic [SW-1:0] DEPTH_S   = SW'(LOG_DEPTH);

  function automatic logic [IW-1:0] ring_add(logic [IW-1:0] head, logic [FW-1:0] fill);
    logic [SW-1:0] s;
    s = SW'(head) + SW'(fill);
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] ring_inc(logic [IW-1:0] idx);
    return (idx == IDX_LAST) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [IW-1:0] ring_dec(logic [IW-1:0] idx);
    return (idx == '0) ? IDX_LAST : idx - 1'b1;
  endfunction

  function automatic vol_t sat_sub(vol_t a, vol_t b);
    return (a >= b) ? a - b : '0;
  endfunction

  // Configuration registers.
  period_t period;
  climit_t climit;
  vol_t    vcap;

  // Latched item.
  logic kind_q;
  logic not_sent_q;
  now_t now_q;
  now_t lower_q;
  id_t  id_q;
  vol_t vol_q;

  // Log pointers and windowed volume.
  logic [IW-1:0] c_head;
  logic [FW-1:0] c_fill;
  logic [IW-1:0] v_head;
  logic [FW-1:0] v_fill;
  vol_t          vsum;
  logic          verdict_q;

  // Memories and their registered read data.
  now_t c_time_mem [LOG_DEPTH];
  id_t  c_id_mem   [LOG_DEPTH];
  now_t v_time_mem [LOG_DEPTH];
  vol_t v_amt_mem  [LOG_DEPTH];
  id_t  v_id_mem   [LOG_DEPTH];
  now_t c_time_rd;
  id_t  c_id_rd;
  now_t v_time_rd;
  vol_t v_amt_rd;
  id_t  v_id_rd;

  logic [IW-1:0] c_slot;
  logic [IW-1:0] v_slot;
  logic [IW-1:0] c_rd_addr;
  logic [IW-1:0] v_rd_addr;
  logic          rb_c;
  logic          rb_v;

  assign c_slot    = ring_add(c_head, c_fill);
  assign v_slot    = ring_add(v_head, v_fill);
  assign c_rd_addr = cmd.rd_tail ? ring_dec(c_slot) : c_head;
  assign v_rd_addr = cmd.rd_tail ? ring_dec(v_slot) : v_head;

  assign rb_c = (c_fill != '0) && (c_id_rd == id_q);
  assign rb_v = (v_fill != '0) && (v_id_rd == id_q);

  always_comb begin
    status.kind     = kind_q;
    status.not_sent = not_sent_q;
    status.disabled = ((climit == '0) && (vcap == '0)) || (period == '0);
    status.c_en     = (climit != '0);
    status.v_en     = (vcap != '0);
    status.c_evict  = (c_fill != '0) && (c_time_rd <= lower_q);
    status.c_full   = (CMPW'(c_fill) >= CMPW'(climit)) || (c_fill == FILL_FULL);
    status.v_evict  = (v_fill != '0) && (v_time_rd <= lower_q);
    status.v_over   = ({1'b0, vsum} + {1'b0, vol_q}) > {1'b0, vcap};
    status.v_full   = (v_fill == FILL_FULL);
  end

  always_ff @(posedge clk) begin
    if (cmd.c_append) begin
      c_time_mem[c_slot] <= now_q;
      c_id_mem[c_slot]   <= id_q;
    end
    c_time_rd <= c_time_mem[c_rd_addr];
    c_id_rd   <= c_id_mem[c_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.v_append) begin
      v_time_mem[v_slot] <= now_q;
      v_amt_mem[v_slot]  <= vol_q;
      v_id_mem[v_slot]   <= id_q;
    end
    v_time_rd <= v_time_mem[v_rd_addr];
    v_amt_rd  <= v_amt_mem[v_rd_addr];
    v_id_rd   <= v_id_mem[v_rd_addr];
  end

  // Item payload and the lower bound of the window, saturated at zero.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_q     <= kind;
      not_sent_q <= not_sent;
      now_q      <= now_ms;
      id_q       <= request_id;
      vol_q      <= request_volume;
      lower_q    <= (now_ms >= NOW_W'(period)) ? now_ms - NOW_W'(period) : '0;
    end
    if (cmd.out_load) begin
      verdict <= verdict_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period    <= '0;
      climit    <= '0;
      vcap      <= '0;
      c_head    <= '0;
      c_fill    <= '0;
      v_head    <= '0;
      v_fill    <= '0;
      vsum      <= '0;
      verdict_q <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WINDOW_PERIOD: period <= cfg_data[PERIOD_W-1:0];
          CFG_COUNT_LIMIT:   climit <= cfg_data[CLIMIT_W-1:0];
          CFG_VOLUME_CAP:    vcap   <= cfg_data[VOL_W-1:0];
          default: ;
        endcase
      end

      priority if (cmd.c_evict) begin
        c_head <= ring_inc(c_head);
        c_fill <= c_fill - 1'b1;
      end else if (cmd.c_append) begin
        c_fill <= c_fill + 1'b1;
      end else if (cmd.rollback && rb_c) begin
        c_fill <= c_fill - 1'b1;
      end

      priority if (cmd.v_evict) begin
        vsum   <= sat_sub(vsum, v_amt_rd);
        v_head <= ring_inc(v_head);
        v_fill <= v_fill - 1'b1;
      end else if (cmd.v_append) begin
        vsum   <= vsum + vol_q;
        v_fill <= v_fill + 1'b1;
      end else if (cmd.rollback && rb_v) begin
        vsum   <= sat_sub(vsum, v_amt_rd);
        v_fill <= v_fill - 1'b1;
      end

      priority if (cmd.latch) begin
        verdict_q <= 1'b0;
      end else if (cmd.verdict_set) begin
        verdict_q <= 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_c_fill_bound: assert property (@(posedge clk) disable iff (rst) c_fill <= FILL_FULL)
    else $error("count log fill beyond depth");
  a_v_fill_bound: assert property (@(posedge clk) disable iff (rst) v_fill <= FILL_FULL)
    else $error("volume log fill beyond depth");
  a_empty_sum: assert property (@(posedge clk) disable iff (rst) (v_fill == '0) |-> (vsum == '0))
    else $error("windowed volume non-zero with empty volume log");
  a_c_append_room: assert property (@(posedge clk) disable iff (rst)
      cmd.c_append |=> (c_fill != '0) && ($past(c_fill) < FILL_FULL))
    else $error("count log append without room");
`endif

endmodule

[rtl/swrl_ctrl.sv]
// Controller of the rate limiter: sequences eviction, append, rollback and the result beat.
module swrl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  swrl_pkg::dp_status_t status,
  output swrl_pkg::dp_cmd_t    cmd
);
  import swrl_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        priority if (status.kind == KIND_REJECT) begin
          state_next = status.not_sent ? ST_RB_RD : ST_FINISH;
        end else if (status.disabled) begin
          state_next = ST_FINISH;
        end else if (status.c_en) begin
          state_next = ST_CNT_RD;
        end else begin
          state_next = ST_VOL_RD;
        end
      end
      ST_CNT_RD:  state_next = ST_CNT_CMP;
      ST_CNT_CMP: begin
        priority if (status.c_evict) begin
          state_next = ST_CNT_RD;
        end else if (status.c_full) begin
          state_next = ST_FINISH;
        end else if (status.v_en) begin
          state_next = ST_VOL_RD;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_VOL_RD:  state_next = ST_VOL_CMP;
      ST_VOL_CMP: state_next = status.v_evict ? ST_VOL_RD : ST_FINISH;
      ST_RB_RD:   state_next = ST_RB_CMP;
      ST_RB_CMP:  state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // No beat is taken while reset is held.
        in_ready  = !rst;
        cmd.latch = in_valid && !rst;
      end
      ST_CNT_CMP: begin
        priority if (status.c_evict) begin
          cmd.c_evict = 1'b1;
        end else if (status.c_full) begin
          cmd.verdict_set = 1'b1;
        end else begin
          cmd.c_append = 1'b1;
        end
      end
      ST_VOL_CMP: begin
        priority if (status.v_evict) begin
          cmd.v_evict = 1'b1;
        end else if (status.v_over || status.v_full) begin
          cmd.verdict_set = 1'b1;
        end else begin
          cmd.v_append = 1'b1;
        end
      end
      ST_RB_RD:  cmd.rd_tail  = 1'b1;
      ST_RB_CMP: cmd.rollback = 1'b1;
      ST_FINISH: cmd.out_load = out_free;
      default: ;
    endcase
  end

endmodule

[rtl/sliding_window_rate_limiter_core.sv]
// Top level of the sliding-window rate limiter: channels, controller and datapath.
//
// The block admits or throttles requests against two sliding-window logs held in
// on-chip memories of LOG_DEPTH entries each: a count log and a volume log. A check
// beat evicts expired entries oldest first, then refuses the request if the count
// log is at its limit or full, or the windowed volume plus the request would exceed
// the cap or the volume log is full, and otherwise appends it; a rejection beat
// marked not sent rolls back the newest entry of each log if its id matches. Every
// request beat gives exactly one verdict beat. The block works on one beat at a
// time. Each log entry visited is first read from the registered memory and then
// compared and evicted, or the request is throttled or appended; a log whose limit
// is zero is not visited, the volume log is skipped when the count log throttles,
// and a check with limiting disabled visits neither log. A rejection that rolls back
// reads the newest entry of each log and then removes it on an id match. A new
// request beat can be taken in the cycle after the previous verdict is loaded into
// the output register, even when that verdict has not yet been taken.
// Configuration writes are accepted in every cycle outside reset and must only be
// issued while the block is idle.
module sliding_window_rate_limiter_core #(
  parameter int LOG_DEPTH = 64
) (
  input logic        clk,
  input logic        rst,
  swrl_req_if.sink   req,
  swrl_rsp_if.source rsp,
  swrl_cfg_if.sink   cfg
);
  import swrl_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Register writes never stall outside reset.
  assign cfg.ready = !rst;

  swrl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  swrl_datapath #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .kind           (req.kind),
    .now_ms         (req.now_ms),
    .request_id     (req.request_id),
    .request_volume (req.request_volume),
    .not_sent       (req.not_sent),
    .cfg_we         (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .verdict        (rsp.verdict)
  );

endmodule
